/* hdl/fbx_pkg.sv */
package fbx_pkg;

	// largest frame in bytes: marker, length, sequence, type, payload, parity
	localparam int MAX_FRAME = 64;

	// longest payload a header may announce
	localparam logic [8:0] LEN_LIMIT = 9'(MAX_FRAME - 5);

	// the length byte counts sequence, type and parity on top of the payload
	localparam logic [7:0] LEN_EXTRA = 8'd3;

	localparam logic [7:0] MARKER_RESET = 8'd126;

	// command codes on the item channel
	localparam logic CMD_HEADER = 1'b0;
	localparam logic CMD_DATA   = 1'b1;

	// most results a single item can cause
	localparam int MAX_RESULTS = 5;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef struct packed {
		logic [7:0] byte_val;
		logic       frame_end;
		logic       error;
	} res_t;

	// results of one accepted item, slot 0 goes out first
	typedef struct packed {
		logic [CNT_W-1:0]            count;
		res_t [MAX_RESULTS-1:0]      res;
	} burst_t;

endpackage

/* hdl/fbx_item_if.sv */
interface fbx_item_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] data_byte;
	logic [7:0] sequence_req;
	logic [7:0] message_type;
	logic [7:0] frame_data_len;

	modport source (output valid, cmd, data_byte, sequence_req, message_type, frame_data_len,
		input ready);
	modport sink (input valid, cmd, data_byte, sequence_req, message_type, frame_data_len,
		output ready);
endinterface

/* hdl/fbx_result_if.sv */
interface fbx_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_end;
	logic       error;

	modport source (output valid, out_byte, frame_end, error, input ready);
	modport sink (input valid, out_byte, frame_end, error, output ready);
endinterface

/* hdl/fbx_cfg_if.sv */
interface fbx_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] start_marker;

	modport source (output valid, start_marker, input ready);
	modport sink (input valid, start_marker, output ready);
endinterface

/* hdl/fbx_frame.sv */
module fbx_frame (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic            cmd,
	input  logic [7:0]      data_byte,
	input  logic [7:0]      sequence_req,
	input  logic [7:0]      message_type,
	input  logic [7:0]      frame_data_len,
	input  logic            cfg_valid,
	input  logic [7:0]      cfg_data,
	output logic            cfg_ready,
	output fbx_pkg::burst_t burst
);

	logic [7:0] marker_q;
	logic [7:0] bytes_left_q;
	logic [7:0] parity_q;
	logic       in_frame_q;

	logic [7:0] bytes_left_d;
	logic [7:0] parity_d;
	logic       in_frame_d;
	logic       too_long;
	logic [7:0] parity_next;

	assign cfg_ready   = 1'b1;
	assign too_long    = {1'b0, frame_data_len} > fbx_pkg::LEN_LIMIT;
	assign parity_next = parity_q ^ data_byte;

	always_comb begin
		burst        = '0;
		bytes_left_d = bytes_left_q;
		parity_d     = parity_q;
		in_frame_d   = in_frame_q;
		if (cmd == fbx_pkg::CMD_HEADER) begin
			if (too_long) begin
				// drop any open frame
				burst.count        = fbx_pkg::CNT_W'(1);
				burst.res[0].error = 1'b1;
				bytes_left_d       = '0;
				parity_d           = '0;
				in_frame_d         = 1'b0;
			end else begin
				burst.res[0].byte_val = marker_q;
				burst.res[1].byte_val = 8'(frame_data_len + fbx_pkg::LEN_EXTRA);
				burst.res[2].byte_val = sequence_req;
				burst.res[3].byte_val = message_type;
				parity_d              = message_type;
				bytes_left_d          = frame_data_len;
				if (frame_data_len == '0) begin
					// empty payload closes right away
					burst.count            = fbx_pkg::CNT_W'(5);
					burst.res[4].byte_val  = message_type;
					burst.res[4].frame_end = 1'b1;
					in_frame_d             = 1'b0;
				end else begin
					burst.count = fbx_pkg::CNT_W'(4);
					in_frame_d  = 1'b1;
				end
			end
		end else if (!in_frame_q) begin
			// stray data byte, state untouched
			burst.count        = fbx_pkg::CNT_W'(1);
			burst.res[0].error = 1'b1;
		end else begin
			burst.res[0].byte_val = data_byte;
			parity_d              = parity_next;
			bytes_left_d          = bytes_left_q - 8'd1;
			if (bytes_left_q == 8'd1) begin
				burst.count            = fbx_pkg::CNT_W'(2);
				burst.res[1].byte_val  = parity_next;
				burst.res[1].frame_end = 1'b1;
				in_frame_d             = 1'b0;
			end else begin
				burst.count = fbx_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q     <= fbx_pkg::MARKER_RESET;
			bytes_left_q <= '0;
			parity_q     <= '0;
			in_frame_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				marker_q <= cfg_data;
			end
			if (take) begin
				bytes_left_q <= bytes_left_d;
				parity_q     <= parity_d;
				in_frame_q   <= in_frame_d;
			end
		end
	end

endmodule

/* hdl/fbx_emit.sv */
module fbx_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  fbx_pkg::burst_t burst,
	output logic            free,
	input  logic            out_ready,
	output logic            out_valid,
	output fbx_pkg::res_t   out_res
);

	fbx_pkg::res_t [fbx_pkg::MAX_RESULTS-1:0] slot_q;
	logic [fbx_pkg::CNT_W-1:0]                 cnt_q;
	logic                                      out_valid_q;
	fbx_pkg::res_t                             out_q;

	logic out_open;
	logic move;

	// output register can take a new result
	assign out_open  = !out_valid_q || out_ready;
	assign move      = out_open && (cnt_q != '0);
	// next burst may land once the last queued result leaves
	assign free      = (cnt_q == '0) || (cnt_q == fbx_pkg::CNT_W'(1) && out_open);
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cnt_q <= burst.count;
			end else if (move) begin
				cnt_q <= cnt_q - fbx_pkg::CNT_W'(1);
			end
			if (out_open) begin
				out_valid_q <= cnt_q != '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= burst.res;
		end else if (move) begin
			slot_q <= {fbx_pkg::res_t'('0), slot_q[fbx_pkg::MAX_RESULTS-1:1]};
		end
		if (move) begin
			out_q <= slot_q[0];
		end
	end

endmodule

/* hdl/frame_builder_xor_parity.sv */
// channel   dir   handshake      payload
// item      in    valid/ready    cmd, data_byte, sequence_req, message_type, frame_data_len
// result    out   valid/ready    out_byte, frame_end, error
// cfg       in    valid/ready    start_marker (ready tied high)
//
// one result leaves per cycle while result is ready; a data item inside a frame queues one
// result, two when it closes the frame, a header four or five, a single error result when
// its length is too long; the queue drains one slot per cycle while the output is open
// an accepted item reaches result through its queue slot and then the output register
// arst_n clears frame state and queue, marker returns to 126
// result stall holds the output; item ready on an empty queue or as its last result leaves
module frame_builder_xor_parity (
	input logic           clk,
	input logic           arst_n,
	fbx_item_if.sink      item,
	fbx_result_if.source  result,
	fbx_cfg_if.sink       cfg
);

	fbx_pkg::burst_t burst;
	fbx_pkg::res_t   res;
	logic            queue_free;
	logic            take;

	// item transfer only when the result queue is free for a new burst
	assign item.ready = queue_free;
	assign take       = item.valid && queue_free;

	// frame state, marker register, result forming
	fbx_frame u_frame (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.cmd            (item.cmd),
		.data_byte      (item.data_byte),
		.sequence_req   (item.sequence_req),
		.message_type   (item.message_type),
		.frame_data_len (item.frame_data_len),
		.cfg_valid      (cfg.valid),
		.cfg_data       (cfg.start_marker),
		.cfg_ready      (cfg.ready),
		.burst          (burst)
	);

	// result queue and output register
	fbx_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.burst     (burst),
		.free      (queue_free),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.out_res   (res)
	);

	assign result.out_byte  = res.byte_val;
	assign result.frame_end = res.frame_end;
	assign result.error     = res.error;

endmodule

/* hdl/fbx_checker.sv */
module fbx_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       item_cmd,
	input logic [7:0] item_len,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] res_byte,
	input logic       res_end,
	input logic       res_error
);

	// a legal header queues at least four results, so no transfer right after it
	a_header_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_cmd == fbx_pkg::CMD_HEADER
			&& {1'b0, item_len} <= fbx_pkg::LEN_LIMIT |=> !item_ready)
		else $error("item ready right after header transfer");

	// error results carry a zero byte and never close a frame
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_error |-> res_byte == 8'd0 && !res_end)
		else $error("malformed error result");

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_byte) && $stable(res_end)
			&& $stable(res_error))
		else $error("stalled result changed");

endmodule

bind frame_builder_xor_parity fbx_checker u_fbx_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item.valid),
	.item_ready (item.ready),
	.item_cmd   (item.cmd),
	.item_len   (item.frame_data_len),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_byte   (result.out_byte),
	.res_end    (result.frame_end),
	.res_error  (result.error)
);
